// ===== rtl/pcie_msi_vector_controller_core_defines.svh =====
// ----------------------------------------------------------------------------
// PCIe MSI vector controller assertion macros
// Shared concurrent assertion forms for the controller RTL.
// ----------------------------------------------------------------------------
`ifndef PCIE_MSI_VECTOR_CONTROLLER_CORE_DEFINES_SVH
`define PCIE_MSI_VECTOR_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PMVC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pmvc assertion failed");

// Next-cycle implication, disabled during reset.
`define PMVC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pmvc assertion failed");

`endif

// ===== rtl/pmvc_pkg.sv =====
// ----------------------------------------------------------------------------
// PCIe MSI vector controller package
// Constants, command codes, types and helper functions of the controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pmvc_pkg;

   localparam int NUM_GROUPS    = 8;
   localparam int VEC_PER_GROUP = 32;
   localparam int MAX_VECTORS   = 256;

   localparam int CMD_W    = 3;
   localparam int GROUP_W  = 3;
   localparam int WORD_W   = 32;
   localparam int ADDR_W   = 32;
   localparam int PAYLOAD_W = 16;
   localparam int VEC_W    = 8;
   localparam int BIT_W    = 5;
   localparam int CSR_IDX_W = 1;

   localparam logic [CMD_W-1:0] CMD_READ_ENABLE  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE_ENABLE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_READ_STATUS  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR_STATUS = 3'd3;
   localparam logic [CMD_W-1:0] CMD_MSI_WRITE    = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_LOW  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_HIGH = 1'd1;

   typedef struct packed {
      logic [CMD_W-1:0]     cmd;
      logic [GROUP_W-1:0]   group;
      logic [WORD_W-1:0]    write_data;
      logic [ADDR_W-1:0]    msi_address_low;
      logic [ADDR_W-1:0]    msi_address_high;
      logic [PAYLOAD_W-1:0] msi_payload;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] read_data;
      logic              interrupt_line;
      logic              pending_valid;
      logic [VEC_W-1:0]  pending_vector;
      logic              msi_accepted;
   } rsp_type;

   function automatic logic group_ok(input logic [GROUP_W-1:0] g);
      return ({1'b0, g} < (GROUP_W+1)'(NUM_GROUPS));
   endfunction

   function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_W-1:0] w);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (w[i]) begin
            idx = BIT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== rtl/pmvc_channels.sv =====
// ----------------------------------------------------------------------------
// PCIe MSI vector controller channels
// Valid/ready interfaces for the request and response items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pmvc_req_if;
   import pmvc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     cmd;
   logic [GROUP_W-1:0]   group;
   logic [WORD_W-1:0]    write_data;
   logic [ADDR_W-1:0]    msi_address_low;
   logic [ADDR_W-1:0]    msi_address_high;
   logic [PAYLOAD_W-1:0] msi_payload;

   modport source (output valid, cmd, group, write_data, msi_address_low,
                   msi_address_high, msi_payload, input ready);
   modport sink (input valid, cmd, group, write_data, msi_address_low,
                 msi_address_high, msi_payload, output ready);
endinterface

interface pmvc_rsp_if;
   import pmvc_pkg::*;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] read_data;
   logic              interrupt_line;
   logic              pending_valid;
   logic [VEC_W-1:0]  pending_vector;
   logic              msi_accepted;

   modport source (output valid, read_data, interrupt_line, pending_valid,
                   pending_vector, msi_accepted, input ready);
   modport sink (input valid, read_data, interrupt_line, pending_valid,
                 pending_vector, msi_accepted, output ready);
endinterface

// ===== rtl/pcie_msi_vector_controller_core.sv =====
// ----------------------------------------------------------------------------
// PCIe MSI vector controller core
// Enable and status registers for 256 MSI vectors, inbound MSI matching,
// interrupt line and lowest pending vector report.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake      Carries
// req_if   in         valid/ready    bus access or inbound MSI write
// rsp_if   out        valid/ready    read data, interrupt, pending vector
// csr_*    in         write enable   target address halves
//
// An item is taken into the input register at its accepting edge and moves on
// into the result register at the first edge at which that register may advance,
// from where its response is offered.
// One item is accepted per cycle unless a stalled response holds the input register;
// the register update and lowest-vector search between the two registers are combinational.
// A stalled response holds both stages; reset is synchronous and clears all
// valid flags, enable words, status words and the target address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pcie_msi_vector_controller_core_defines.svh"

module pcie_msi_vector_controller_core
   import pmvc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   pmvc_req_if.sink             req_if,
   pmvc_rsp_if.source           rsp_if,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_write_data
);

   logic                  s1_valid_ff;
   req_type               s1_ff;
   logic                  out_valid_ff;
   rsp_type               out_ff;
   rsp_type               out_in;
   logic [ADDR_W-1:0]     target_low_ff;
   logic [ADDR_W-1:0]     target_high_ff;
   logic [WORD_W-1:0]     enable_ff [NUM_GROUPS];
   logic [WORD_W-1:0]     status_ff [NUM_GROUPS];
   logic [WORD_W-1:0]     enable_in [NUM_GROUPS];
   logic [WORD_W-1:0]     status_in [NUM_GROUPS];
   logic [WORD_W-1:0]     pend [NUM_GROUPS];
   logic [BIT_W-1:0]      pend_bit [NUM_GROUPS];
   logic                  advance;
   logic                  process;
   logic                  addr_hit;
   logic [GROUP_W-1:0]    msi_group;
   logic [BIT_W-1:0]      msi_bit;

   assign advance      = !out_valid_ff || rsp_if.ready;
   assign process      = s1_valid_ff && advance;
   assign req_if.ready = !s1_valid_ff || advance;

   assign addr_hit  = (s1_ff.msi_address_low == target_low_ff) &&
                      (s1_ff.msi_address_high == target_high_ff) &&
                      (s1_ff.msi_payload[PAYLOAD_W-1:VEC_W] == '0);
   assign msi_group = s1_ff.msi_payload[VEC_W-1:BIT_W];
   assign msi_bit   = s1_ff.msi_payload[BIT_W-1:0];

   always_comb begin
      out_in = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         enable_in[g] = enable_ff[g];
         status_in[g] = status_ff[g];
      end
      case (s1_ff.cmd)
         CMD_READ_ENABLE: begin
            if (group_ok(s1_ff.group)) begin
               out_in.read_data = enable_ff[s1_ff.group];
            end
         end
         CMD_WRITE_ENABLE: begin
            if (group_ok(s1_ff.group)) begin
               enable_in[s1_ff.group] = s1_ff.write_data;
            end
         end
         CMD_READ_STATUS: begin
            if (group_ok(s1_ff.group)) begin
               out_in.read_data = status_ff[s1_ff.group];
            end
         end
         CMD_CLEAR_STATUS: begin
            if (group_ok(s1_ff.group)) begin
               status_in[s1_ff.group] = status_ff[s1_ff.group] & ~s1_ff.write_data;
            end
         end
         CMD_MSI_WRITE: begin
            if (addr_hit && group_ok(msi_group) && enable_ff[msi_group][msi_bit]) begin
               status_in[msi_group][msi_bit] = 1'b1;
               out_in.msi_accepted = 1'b1;
            end
         end
         default: begin
         end
      endcase

      for (int g = 0; g < NUM_GROUPS; g++) begin
         pend[g]     = status_in[g] & enable_in[g];
         pend_bit[g] = lowest_bit(pend[g]);
      end
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if (pend[g] != '0) begin
            out_in.pending_valid  = 1'b1;
            out_in.pending_vector = {GROUP_W'(g), pend_bit[g]};
         end
      end
      out_in.interrupt_line = out_in.pending_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         target_low_ff  <= '0;
         target_high_ff <= '0;
         for (int g = 0; g < NUM_GROUPS; g++) begin
            enable_ff[g] <= '0;
            status_ff[g] <= '0;
         end
      end else begin
         if (req_if.ready) begin
            s1_valid_ff <= req_if.valid;
         end
         if (advance) begin
            out_valid_ff <= s1_valid_ff;
         end
         if (process) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
               enable_ff[g] <= enable_in[g];
               status_ff[g] <= status_in[g];
            end
         end
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_TARGET_LOW:  target_low_ff  <= csr_write_data;
               CSR_TARGET_HIGH: target_high_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         s1_ff.cmd              <= req_if.cmd;
         s1_ff.group            <= req_if.group;
         s1_ff.write_data       <= req_if.write_data;
         s1_ff.msi_address_low  <= req_if.msi_address_low;
         s1_ff.msi_address_high <= req_if.msi_address_high;
         s1_ff.msi_payload      <= req_if.msi_payload;
      end
      if (process) begin
         out_ff <= out_in;
      end
   end

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.read_data      = out_ff.read_data;
   assign rsp_if.interrupt_line = out_ff.interrupt_line;
   assign rsp_if.pending_valid  = out_ff.pending_valid;
   assign rsp_if.pending_vector = out_ff.pending_vector;
   assign rsp_if.msi_accepted   = out_ff.msi_accepted;

   `PMVC_ASSERT_NOW(a_accept_raises_irq, clock, reset, out_valid_ff && out_ff.msi_accepted, out_ff.interrupt_line)
   `PMVC_ASSERT_NOW(a_idle_vector_zero, clock, reset, out_valid_ff && !out_ff.pending_valid, out_ff.pending_vector == '0)
   `PMVC_ASSERT_NEXT(a_stall_holds_item, clock, reset, s1_valid_ff && out_valid_ff && !rsp_if.ready, s1_valid_ff && out_valid_ff)
   `PMVC_ASSERT_NEXT(a_state_frozen, clock, reset, !process, (enable_ff[0] == $past(enable_ff[0])) && (status_ff[0] == $past(status_ff[0])))

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// PCIe MSI vector controller testbench
// Drives bus accesses and inbound MSI writes into the controller under
// random stalls on both channels, predicts every response from a shadow copy
// of the enable words, status words and target address, and compares each
// response field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import pmvc_pkg::*;

   localparam int              CYCLE_LIMIT     = 200000;
   localparam int              RANDOM_PER_PASS = 150;
   localparam logic [CMD_W-1:0] CMD_UNUSED_LO  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNUSED_HI  = 3'd7;

   class msi_vector_scoreboard;
      logic [WORD_W-1:0] enable_words [NUM_GROUPS];
      logic [WORD_W-1:0] status_words [NUM_GROUPS];
      logic [ADDR_W-1:0] target_low;
      logic [ADDR_W-1:0] target_high;
      rsp_type           predicted_rsps [$];
      int                error_count;

      function new();
         foreach (enable_words[g]) begin
            enable_words[g] = '0;
            status_words[g] = '0;
         end
         target_low  = '0;
         target_high = '0;
         error_count = 0;
      endfunction

      function void set_target(input logic [CSR_IDX_W-1:0] index,
                               input logic [WORD_W-1:0] data);
         case (index)
            CSR_TARGET_LOW:  target_low  = data;
            CSR_TARGET_HIGH: target_high = data;
            default: ;
         endcase
      endfunction

      function void note_request(input req_type r);
         rsp_type           e;
         logic [VEC_W-1:0]  vector;
         logic [WORD_W-1:0] mask;
         logic [WORD_W-1:0] live;
         bit                found;
         e     = '0;
         found = 1'b0;
         case (r.cmd)
            CMD_READ_ENABLE: begin
               if (r.group < NUM_GROUPS) e.read_data = enable_words[r.group];
            end
            CMD_WRITE_ENABLE: begin
               if (r.group < NUM_GROUPS) enable_words[r.group] = r.write_data;
            end
            CMD_READ_STATUS: begin
               if (r.group < NUM_GROUPS) e.read_data = status_words[r.group];
            end
            CMD_CLEAR_STATUS: begin
               if (r.group < NUM_GROUPS)
                  status_words[r.group] = status_words[r.group] & ~r.write_data;
            end
            CMD_MSI_WRITE: begin
               if (r.msi_address_low == target_low && r.msi_address_high == target_high
                   && r.msi_payload < MAX_VECTORS) begin
                  vector = r.msi_payload[VEC_W-1:0];
                  mask   = WORD_W'(1) << vector[BIT_W-1:0];
                  if (vector[VEC_W-1:BIT_W] < NUM_GROUPS
                      && (enable_words[vector[VEC_W-1:BIT_W]] & mask) != '0) begin
                     status_words[vector[VEC_W-1:BIT_W]] |= mask;
                     e.msi_accepted = 1'b1;
                  end
               end
            end
            default: ;
         endcase
         for (int g = 0; g < NUM_GROUPS; g++) begin
            live = status_words[g] & enable_words[g];
            for (int b = 0; b < VEC_PER_GROUP; b++) begin
               if (!found && live[b]) begin
                  found            = 1'b1;
                  e.interrupt_line = 1'b1;
                  e.pending_valid  = 1'b1;
                  e.pending_vector = VEC_W'(g * VEC_PER_GROUP + b);
               end
            end
         end
         predicted_rsps.push_back(e);
      endfunction

      function void compare_field(input string name, input logic [WORD_W-1:0] want,
                                  input logic [WORD_W-1:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            error_count++;
         end
      endfunction

      function void check_response(input rsp_type got);
         rsp_type want;
         if (predicted_rsps.size() == 0) begin
            $display("%0t: unexpected response item: actual 0x%0h", $time, got);
            error_count++;
            return;
         end
         want = predicted_rsps.pop_front();
         compare_field("read_data", want.read_data, got.read_data);
         compare_field("interrupt_line", WORD_W'(want.interrupt_line),
                       WORD_W'(got.interrupt_line));
         compare_field("pending_valid", WORD_W'(want.pending_valid),
                       WORD_W'(got.pending_valid));
         compare_field("pending_vector", WORD_W'(want.pending_vector),
                       WORD_W'(got.pending_vector));
         compare_field("msi_accepted", WORD_W'(want.msi_accepted),
                       WORD_W'(got.msi_accepted));
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WORD_W-1:0]    csr_write_data;
   bit                   stall_enable;
   rsp_type              observed;

   msi_vector_scoreboard scoreboard = new();

   pmvc_req_if req_if ();
   pmvc_rsp_if rsp_if ();

   pcie_msi_vector_controller_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if.sink),
      .rsp_if           (rsp_if.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAIL pcie_msi_vector_controller_core");
      $finish;
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready = !(stall_enable && $urandom_range(99) < 21);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready) begin
         observed.read_data      = rsp_if.read_data;
         observed.interrupt_line = rsp_if.interrupt_line;
         observed.pending_valid  = rsp_if.pending_valid;
         observed.pending_vector = rsp_if.pending_vector;
         observed.msi_accepted   = rsp_if.msi_accepted;
         scoreboard.check_response(observed);
      end
   end

   // Entered and left at a falling edge.
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [GROUP_W-1:0] group,
                               input logic [WORD_W-1:0] data, input logic [ADDR_W-1:0] alo,
                               input logic [ADDR_W-1:0] ahi,
                               input logic [PAYLOAD_W-1:0] payload);
      req_type r;
      r = '{cmd, group, data, alo, ahi, payload};
      while (stall_enable && $urandom_range(99) < 21) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.cmd              = cmd;
      req_if.group            = group;
      req_if.write_data       = data;
      req_if.msi_address_low  = alo;
      req_if.msi_address_high = ahi;
      req_if.msi_payload      = payload;
      req_if.valid            = 1'b1;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      scoreboard.note_request(r);
      @(negedge clock);
      req_if.valid = 1'b0;
   endtask

   task automatic bus_access(input logic [CMD_W-1:0] cmd, input logic [GROUP_W-1:0] group,
                             input logic [WORD_W-1:0] data);
      send_request(cmd, group, data, $urandom, $urandom, PAYLOAD_W'($urandom));
   endtask

   task automatic msi_write(input logic [ADDR_W-1:0] alo, input logic [ADDR_W-1:0] ahi,
                            input logic [PAYLOAD_W-1:0] payload);
      send_request(CMD_MSI_WRITE, GROUP_W'($urandom), $urandom, alo, ahi, payload);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [WORD_W-1:0] data);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_write_data   = data;
      @(negedge clock);
      scoreboard.set_target(index, data);
      csr_write_enable = 1'b0;
   endtask

   // The target address may only change once the pipeline has drained.
   task automatic program_target(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
      while (scoreboard.predicted_rsps.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      write_csr(CSR_TARGET_LOW, lo);
      write_csr(CSR_TARGET_HIGH, hi);
   endtask

   task automatic send_random_request();
      int                pick;
      logic [ADDR_W-1:0] alo;
      logic [ADDR_W-1:0] ahi;
      logic [WORD_W-1:0] data;
      pick = $urandom_range(99);
      alo  = scoreboard.target_low;
      ahi  = scoreboard.target_high;
      if (pick < 40) begin
         if ($urandom_range(9) == 0)
            msi_write(alo, ahi, PAYLOAD_W'($urandom_range(65535, MAX_VECTORS)));
         else
            msi_write(alo, ahi, PAYLOAD_W'($urandom_range(MAX_VECTORS - 1)));
      end else if (pick < 50) begin
         case ($urandom_range(2))
            0: alo ^= ADDR_W'(1) << $urandom_range(ADDR_W - 1);
            1: ahi ^= ADDR_W'(1) << $urandom_range(ADDR_W - 1);
            default: begin
               alo = $urandom;
               ahi = $urandom;
            end
         endcase
         msi_write(alo, ahi, PAYLOAD_W'($urandom));
      end else if (pick < 65) begin
         case ($urandom_range(3))
            0: data = '1;
            1: data = $urandom & $urandom & $urandom;
            default: data = $urandom;
         endcase
         bus_access(CMD_WRITE_ENABLE, GROUP_W'($urandom), data);
      end else if (pick < 77) begin
         if ($urandom_range(1) == 0)
            data = WORD_W'(1) << $urandom_range(WORD_W - 1);
         else
            data = $urandom;
         bus_access(CMD_CLEAR_STATUS, GROUP_W'($urandom), data);
      end else if (pick < 86) begin
         bus_access(CMD_READ_ENABLE, GROUP_W'($urandom), $urandom);
      end else if (pick < 95) begin
         bus_access(CMD_READ_STATUS, GROUP_W'($urandom), $urandom);
      end else begin
         bus_access(CMD_W'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO)),
                    GROUP_W'($urandom), $urandom);
      end
   endtask

   initial begin
      logic [ADDR_W-1:0] tlo;
      logic [ADDR_W-1:0] thi;
      reset                   = 1'b1;
      stall_enable            = 1'b1;
      csr_write_enable        = 1'b0;
      csr_index               = CSR_TARGET_LOW;
      csr_write_data          = '0;
      req_if.valid            = 1'b0;
      req_if.cmd              = CMD_READ_ENABLE;
      req_if.group            = '0;
      req_if.write_data       = '0;
      req_if.msi_address_low  = '0;
      req_if.msi_address_high = '0;
      req_if.msi_payload      = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      program_target('1, '1);
      tlo = scoreboard.target_low;
      thi = scoreboard.target_high;
      bus_access(CMD_READ_ENABLE, 3'd0, '0);
      msi_write(tlo, thi, 16'd5);
      bus_access(CMD_WRITE_ENABLE, 3'd0, '1);
      bus_access(CMD_WRITE_ENABLE, 3'd7, 32'h8000_0001);
      msi_write(tlo, thi, 16'd0);
      msi_write(tlo, thi, 16'd255);
      msi_write(tlo, thi, 16'd5);
      msi_write(tlo, thi, 16'd5);
      msi_write(tlo ^ 32'h1, thi, 16'd6);
      msi_write(tlo, thi ^ 32'h8000_0000, 16'd6);
      msi_write(tlo, thi, 16'd256);
      msi_write(tlo, thi, 16'hFFFF);
      msi_write(tlo, thi, 16'd224);
      bus_access(CMD_READ_STATUS, 3'd0, '0);
      bus_access(CMD_READ_STATUS, 3'd7, '0);
      // Disabling group 0 keeps its status bits but hides them from the pending search.
      bus_access(CMD_WRITE_ENABLE, 3'd0, '0);
      bus_access(CMD_READ_STATUS, 3'd0, '0);
      bus_access(CMD_WRITE_ENABLE, 3'd0, '1);
      bus_access(CMD_CLEAR_STATUS, 3'd0, '1);
      bus_access(CMD_CLEAR_STATUS, 3'd7, 32'h1);
      for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++)
         bus_access(CMD_W'(c), GROUP_W'($urandom), '1);
      bus_access(CMD_READ_ENABLE, 3'd7, '0);
      bus_access(CMD_WRITE_ENABLE, 3'd3, $urandom);
      bus_access(CMD_READ_ENABLE, 3'd3, '0);

      program_target($urandom, $urandom);
      repeat (RANDOM_PER_PASS) send_random_request();

      program_target('0, '0);
      stall_enable = 1'b0;
      repeat (RANDOM_PER_PASS) send_random_request();
      stall_enable = 1'b1;

      program_target(32'hFEE0_0000, '1);
      repeat (RANDOM_PER_PASS) send_random_request();

      while (scoreboard.predicted_rsps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (scoreboard.error_count == 0) begin
         $display("PASS pcie_msi_vector_controller_core");
      end else begin
         $display("FAIL pcie_msi_vector_controller_core");
      end
      $finish;
   end

endmodule
